// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked at every rising edge outside reset.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hdl/mcc_pkg.sv -----
// Types and constants shared by the convolution block.
`default_nettype none
package mcc_pkg;
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int IN_CHANNELS  = 3;
  localparam int OUT_CHANNELS = 64;
  localparam int KERNEL_ROWS  = 3;
  localparam int KERNEL_COLS  = 3;
  localparam int TAPS         = IN_CHANNELS * KERNEL_ROWS * KERNEL_COLS;
  localparam int WEIGHT_DEPTH = OUT_CHANNELS * TAPS;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic       OP_WEIGHT = 1'b0;
  localparam logic       OP_PIXEL  = 1'b1;

  typedef struct packed {
    logic              is_pixel;
    logic              w_ok;
    logic [5:0]        w_row;
    logic [4:0]        w_tap;
    logic signed [15:0] w_value;
    logic [TAPS*8-1:0] window;
    logic [7:0]        row;
    logic [7:0]        col;
  } job_t;
endpackage
`default_nettype wire

// ----- hdl/mcc_front.sv -----
// Front part: frame counters, line buffer, window assembly and weight address split.
`default_nettype none
module mcc_front import mcc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [10:0] weight_index,
  input  wire logic signed [15:0] weight_value,
  input  wire logic [7:0]  pixel_c0,
  input  wire logic [7:0]  pixel_c1,
  input  wire logic [7:0]  pixel_c2,
  output logic             push,
  output job_t             push_job,
  input  wire logic        q_full
);
  localparam logic FS_IDLE = 1'b0;
  localparam logic FS_LOOK = 1'b1;

  logic        state;
  logic [8:0]  frame_width, frame_height;
  logic [8:0]  wc, hc;
  logic [7:0]  col, row, gcol, grow;
  logic [23:0] pix;
  logic [47:0] line_mem [MAX_WIDTH];
  logic [47:0] line_rd;
  logic [TAPS*8-1:0] window, window_next;
  logic        accept, need, done;
  logic [22:0] co_prod;
  logic [5:0]  w_co;
  logic [10:0] w_rest;
  logic [8:0]  col_inc, row_inc;

  always_comb begin
    wc = (frame_width == 9'd0) ? 9'd1 :
         (frame_width > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : frame_width;
    hc = (frame_height == 9'd0) ? 9'd1 :
         (frame_height > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : frame_height;
  end

  assign in_stall = (state != FS_IDLE) || q_full;
  assign accept   = in_valid && !in_stall;

  // Counters left outside the frame start again at the origin.
  always_comb begin
    if ({1'b0, col} >= wc || {1'b0, row} >= hc) begin
      gcol = 8'd0;
      grow = 8'd0;
    end else begin
      gcol = col;
      grow = row;
    end
  end

  // Division by 27 through a reciprocal; exact for every index below WEIGHT_DEPTH (1728).
  assign co_prod = 23'({1'b0, weight_index}) * 23'd2428;
  assign w_co    = co_prod[21:16];
  assign w_rest  = weight_index - 11'(w_co) * 11'd27;

  // The line entry holds the two rows above; the new column slides in at kj = 2.
  always_comb begin
    window_next = window;
    for (int ci = 0; ci < IN_CHANNELS; ci++) begin
      for (int ki = 0; ki < KERNEL_ROWS; ki++) begin
        window_next[((ci*3+ki)*3+0)*8 +: 8] = window[((ci*3+ki)*3+1)*8 +: 8];
        window_next[((ci*3+ki)*3+1)*8 +: 8] = window[((ci*3+ki)*3+2)*8 +: 8];
      end
      window_next[((ci*3+0)*3+2)*8 +: 8] = line_rd[24 + ci*8 +: 8];
      window_next[((ci*3+1)*3+2)*8 +: 8] = line_rd[ci*8 +: 8];
      window_next[((ci*3+2)*3+2)*8 +: 8] = pix[ci*8 +: 8];
    end
  end

  assign need    = (row >= 8'd2) && (col >= 8'd2);
  assign done    = (state == FS_LOOK) && (!need || !q_full);
  assign col_inc = {1'b0, col} + 9'd1;
  assign row_inc = {1'b0, row} + 9'd1;

  always_comb begin
    push_job          = '0;
    push_job.w_ok     = weight_index < 11'(WEIGHT_DEPTH);
    push_job.w_row    = w_co;
    push_job.w_tap    = w_rest[4:0];
    push_job.w_value  = weight_value;
    push_job.window   = window_next;
    push_job.row      = row - 8'd2;
    push_job.col      = col - 8'd2;
    push_job.is_pixel = (state == FS_LOOK);
    push = (accept && opcode == OP_WEIGHT) || (done && need);
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_PIXEL) begin
      line_rd <= line_mem[gcol];
      pix     <= {pixel_c2, pixel_c1, pixel_c0};
    end
    if (done) begin
      line_mem[col] <= {line_rd[23:0], pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= FS_IDLE;
      col          <= 8'd0;
      row          <= 8'd0;
      frame_width  <= 9'd224;
      frame_height <= 9'd224;
      window       <= '0;
    end else begin
      case (state)
        FS_IDLE: begin
          if (accept && opcode == OP_PIXEL) begin
            col   <= gcol;
            row   <= grow;
            state <= FS_LOOK;
          end
        end
        FS_LOOK: begin
          if (done) begin
            window <= window_next;
            state  <= FS_IDLE;
            if (col_inc >= wc) begin
              col <= 8'd0;
              row <= (row_inc >= hc) ? 8'd0 : row_inc[7:0];
            end else begin
              col <= col_inc[7:0];
            end
          end
        end
        default: state <= FS_IDLE;
      endcase
      if (cfg_write && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
        if (cfg_index == REG_FRAME_WIDTH) frame_width <= cfg_data;
        else frame_height <= cfg_data;
        col <= 8'd0;
        row <= 8'd0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/mcc_queue.sv -----
// Two-entry queue of jobs between the front and back parts.
`default_nettype none
module mcc_queue import mcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      head,
  output logic      empty
);
  job_t       slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slot[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push && !full) - 2'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

// ----- hdl/mcc_back.sv -----
// Back part: weight lanes, 27 multipliers and a registered adder tree, one channel a cycle while not stalled.
`default_nettype none
module mcc_back import mcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t head,
  input  wire logic empty,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic [5:0] out_channel,
  output logic [7:0] out_row,
  output logic [7:0] out_col,
  output logic signed [28:0] conv_sum,
  output logic      last
);
  logic              running, en, issue;
  logic [5:0]        co;
  logic [TAPS*8-1:0] window;
  logic [7:0]        job_row, job_col;
  logic signed [15:0] rd_w [TAPS];
  logic signed [24:0] prod [TAPS];
  logic signed [26:0] s1 [9];
  logic signed [28:0] s2 [3];
  logic              rd_v, mul_v, s1_v, s2_v;
  logic [5:0]        rd_co, mul_co, s1_co, s2_co;
  logic [7:0]        rd_r, mul_r, s1_r, s2_r, rd_c, mul_c, s1_c, s2_c;

  assign en    = !out_valid || !out_stall;
  assign issue = running && en;
  // A pixel job waits until the previous window has left the read stage.
  assign pop = !empty && !running && (!head.is_pixel || !rd_v);

  for (genvar t = 0; t < TAPS; t++) begin : g_lane
    logic signed [15:0] mem [OUT_CHANNELS];
    always_ff @(posedge clk) begin
      if (pop && !head.is_pixel && head.w_ok && head.w_tap == 5'(t))
        mem[head.w_row] <= head.w_value;
      if (issue) rd_w[t] <= mem[co];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.is_pixel) begin
      window  <= head.window;
      job_row <= head.row;
      job_col <= head.col;
    end
    if (en) begin
      rd_co <= co;     rd_r <= job_row; rd_c <= job_col;
      mul_co <= rd_co; mul_r <= rd_r;   mul_c <= rd_c;
      s1_co <= mul_co; s1_r <= mul_r;   s1_c <= mul_c;
      s2_co <= s1_co;  s2_r <= s1_r;    s2_c <= s1_c;
      for (int t = 0; t < TAPS; t++)
        prod[t] <= $signed({1'b0, window[t*8 +: 8]}) * rd_w[t];
      for (int g = 0; g < 9; g++)
        s1[g] <= 27'(prod[3*g]) + 27'(prod[3*g+1]) + 27'(prod[3*g+2]);
      for (int g = 0; g < 3; g++)
        s2[g] <= 29'(s1[3*g]) + 29'(s1[3*g+1]) + 29'(s1[3*g+2]);
      conv_sum    <= s2[0] + s2[1] + s2[2];
      out_channel <= s2_co;
      out_row     <= s2_r;
      out_col     <= s2_c;
      last        <= s2_co == 6'(OUT_CHANNELS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      co        <= 6'd0;
      rd_v      <= 1'b0;
      mul_v     <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && head.is_pixel) begin
        running <= 1'b1;
        co      <= 6'd0;
      end else if (issue) begin
        co <= co + 6'd1;
        if (co == 6'(OUT_CHANNELS - 1)) running <= 1'b0;
      end
      if (en) begin
        rd_v      <= issue;
        mul_v     <= rd_v;
        s1_v      <= mul_v;
        s2_v      <= s1_v;
        out_valid <= s2_v;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/multichannel_conv2d_valid.sv -----
// Rate: a pixel that completes a window yields 64 sums, one a cycle while out_stall is low,
// from the back part's 27 multipliers; other pixels pass the front idle and look-up states,
// weight items the idle state only. A window's first sum passes the front look-up, queue, issue,
// read, multiply, two adder and output registers. Reset (rst, synchronous) clears counters, window,
// queue and pipeline and sets both frame sizes to 224; weight and line stores are not cleared.
`default_nettype none
module multichannel_conv2d_valid import mcc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [10:0] weight_index,
  input  wire logic signed [15:0] weight_value,
  input  wire logic [7:0]  pixel_c0,
  input  wire logic [7:0]  pixel_c1,
  input  wire logic [7:0]  pixel_c2,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_channel,
  output logic [7:0]       out_row,
  output logic [7:0]       out_col,
  output logic signed [28:0] conv_sum,
  output logic             last
);
  logic push, q_full, pop, q_empty;
  job_t push_job, head;

  mcc_front u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .opcode, .weight_index, .weight_value, .pixel_c0, .pixel_c1, .pixel_c2,
    .push, .push_job, .q_full
  );

  mcc_queue u_queue (
    .clk, .rst, .push, .push_job, .full(q_full), .pop, .head, .empty(q_empty)
  );

  mcc_back u_back (
    .clk, .rst, .head, .empty(q_empty), .pop, .out_valid, .out_stall,
    .out_channel, .out_row, .out_col, .conv_sum, .last
  );
endmodule
`default_nettype wire

// ----- hdl/mcc_checker.sv -----
// Port-level checker for the convolution block, with its bind.
`default_nettype none
`include "assert_macros.svh"
module mcc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [5:0]  out_channel,
  input wire logic signed [28:0] conv_sum,
  input wire logic        last
);
  `CHK_ASSERT(a_last_chan, clk, rst, out_valid |-> (last == (out_channel == 6'd63)), "last flag disagrees with channel")
  `CHK_ASSERT(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(conv_sum), "stalled sum changed")
  `CHK_ASSERT(a_next_chan, clk, rst, out_valid && !out_stall && !last ##1 out_valid |-> out_channel == $past(out_channel) + 6'd1, "channels out of order")
  `CHK_ASSERT_ALWAYS(a_reset, clk, rst |=> !out_valid, "result shown after reset")
endmodule

bind multichannel_conv2d_valid mcc_checker u_mcc_checker (
  .clk, .rst, .out_valid, .out_stall, .out_channel, .conv_sum, .last
);
`default_nettype wire
